>>> rtl/alpha_over_stack_compositor_top_macros.svh
// Assertion macros for the stack compositor.
// Used by the top level only; no other dependencies.
`ifndef ALPHA_OVER_STACK_COMPOSITOR_TOP_MACROS_SVH
`define ALPHA_OVER_STACK_COMPOSITOR_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AOSC_ASSERT_IMPL(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define AOSC_ASSERT_NEXT(label, clk_s, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

>>> rtl/aosc_pkg.sv
// Package for the stack compositor: widths, codes, state type and command structs.
// No dependencies.
`default_nettype none
package aosc_pkg;
	localparam int unsigned CH_W = 17;
	localparam int unsigned ACC_W = 25;
	localparam int unsigned POS_W = 9;
	localparam int unsigned DEF_MAX_LAYERS = 256;
	localparam logic [CH_W-1:0] ONE_FX = 17'd65536;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_INVALID = 2'd2,
		ST_HIDDEN = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_BLEND,
		S_DIV,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic blend;     // register the blend products into the accumulators
		logic div_start; // load the divider
		logic div_step;  // one quotient bit
		logic clear;     // return to reset state after emitting
		logic out_load;  // capture the result
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic fast_result; // result needs no division
	} dp_stat_t;
endpackage
`default_nettype wire

>>> rtl/aosc_stream_if.sv
// Valid/ready channel interface carrying a generic payload.
// No dependencies.
`default_nettype none
interface aosc_stream_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/alpha_over_stack_compositor_top.sv
// Top level of the source-over layer stack compositor.
// Depends on aosc_pkg, aosc_stream_if, aosc_ctrl, aosc_datapath and the macros header.
//
// Use: layers enter bottom to top on the input channel, one per transaction, as
// 17-bit RGBA with 65536 meaning 1.0. A transaction with last_layer set closes
// the stack and yields exactly one result transaction on the output channel;
// a bare end marker (has_layer low) carries no layer.
// Flow: a layer is first checked and registered, then folded into the
// premultiplied accumulators; the input takes no new layer until the fold is done.
// The closing transaction adds an un-premultiply by the bit-serial divider (one
// quotient bit per cycle for all three colours), unless the result is a fault,
// an empty stack or zero alpha, in which case the divide is skipped.
// The result is then loaded into the output register.
// The result stays in an output register until taken; while it waits the input
// is open again for the next stack, and a second result waits for the first.
// Reset clears all accumulators, the layer count and the fault record, and
// leaves the output channel empty.
`default_nettype none
`include "alpha_over_stack_compositor_top_macros.svh"
module alpha_over_stack_compositor_top import aosc_pkg::*; #(
	parameter int unsigned MAX_LAYERS = DEF_MAX_LAYERS
) (
	input wire logic clk,
	input wire logic arst_n,
	aosc_stream_if.sink in_ch,
	aosc_stream_if.source out_ch
);
	// Input payload: has_layer, red_in, green_in, blue_in, alpha_in, last_layer.
	// Output payload: status, position, red_out, green_out, blue_out, alpha_out.
	dp_cmd_t cmd;
	dp_stat_t stat;
	logic take;

	aosc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.payload.last_layer),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.cmd(cmd), .stat(stat)
	);

	assign take = in_ch.valid && in_ch.ready;

	aosc_datapath #(.MAX_LAYERS(MAX_LAYERS)) u_dp (
		.clk(clk), .arst_n(arst_n), .in_take(take),
		.has_layer(in_ch.payload.has_layer),
		.red_in(in_ch.payload.red_in), .green_in(in_ch.payload.green_in),
		.blue_in(in_ch.payload.blue_in), .alpha_in(in_ch.payload.alpha_in),
		.cmd(cmd), .stat(stat),
		.status(out_ch.payload.status), .position(out_ch.payload.position),
		.red_out(out_ch.payload.red_out), .green_out(out_ch.payload.green_out),
		.blue_out(out_ch.payload.blue_out), .alpha_out(out_ch.payload.alpha_out)
	);

	// A cleared state is only ever requested together with a result load.
	`AOSC_ASSERT_IMPL(a_clear_with_load, clk, arst_n, cmd.clear, cmd.out_load, "clear without load")
	// The divider never steps while the input is open.
	`AOSC_ASSERT_IMPL(a_no_take_in_div, clk, arst_n, cmd.div_step, !in_ch.ready, "input open in divide")
	// A loaded result is presented in the next cycle.
	`AOSC_ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, out_ch.valid, "result not shown")
endmodule
`default_nettype wire

>>> rtl/aosc_datapath.sv
// Datapath: layer checks, source-over accumulators, restoring divider, result register.
// Depends on aosc_pkg.
`default_nettype none
module aosc_datapath import aosc_pkg::*; #(
	parameter int unsigned MAX_LAYERS = DEF_MAX_LAYERS
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_take,
	input wire logic has_layer,
	input wire logic [CH_W-1:0] red_in,
	input wire logic [CH_W-1:0] green_in,
	input wire logic [CH_W-1:0] blue_in,
	input wire logic [CH_W-1:0] alpha_in,
	input wire dp_cmd_t cmd,
	output dp_stat_t stat,
	output logic [1:0] status,
	output logic [POS_W-1:0] position,
	output logic [CH_W-1:0] red_out,
	output logic [CH_W-1:0] green_out,
	output logic [CH_W-1:0] blue_out,
	output logic [CH_W-1:0] alpha_out
);
	localparam int unsigned CNT_W = $clog2(MAX_LAYERS + 1);
	localparam int unsigned QW = 18;

	logic [ACC_W-1:0] acc_q [4];
	logic [CNT_W-1:0] cnt_q;
	logic [1:0] fault_q;
	logic [CNT_W-1:0] fidx_q;
	logic [CH_W-1:0] pix_s1 [4];
	logic valid_s1;

	// Stage 1: register the accepted layer after its checks.
	logic bad, hidden;
	always_comb begin
		bad = (red_in > ONE_FX) || (green_in > ONE_FX) || (blue_in > ONE_FX)
			|| (alpha_in > ONE_FX);
		hidden = (alpha_in == '0) && ((red_in | green_in | blue_in) != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			fault_q <= ST_OK;
			fidx_q <= '0;
		end else begin
			valid_s1 <= 1'b0;
			if (cmd.clear) begin
				fault_q <= ST_OK;
				fidx_q <= '0;
			end else if (in_take && has_layer && fault_q == ST_OK) begin
				if (bad) begin
					fault_q <= ST_INVALID;
					fidx_q <= cnt_q;
				end else if (hidden) begin
					fault_q <= ST_HIDDEN;
					fidx_q <= cnt_q;
				end else begin
					valid_s1 <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pix_s1[0] <= red_in;
			pix_s1[1] <= green_in;
			pix_s1[2] <= blue_in;
			pix_s1[3] <= alpha_in;
		end
	end

	// Blend: per channel a 25x17 product of accumulator and inverse alpha, plus a 17x17 colour-alpha product.
	logic [CH_W-1:0] inv;
	logic [ACC_W-1:0] nxt [4];
	always_comb begin
		inv = ONE_FX - pix_s1[3];
		for (int i = 0; i < 4; i++) begin
			logic [CH_W+ACC_W-1:0] pa;
			logic [2*CH_W-1:0] ps;
			pa = acc_q[i] * inv;
			ps = pix_s1[i] * pix_s1[3];
			if (i == 3)
				nxt[i] = ACC_W'(pix_s1[3]) + pa[16 +: ACC_W];
			else
				nxt[i] = ACC_W'(ps[2*CH_W-1:16]) + pa[16 +: ACC_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			cnt_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= '0;
			cnt_q <= '0;
		end else if (cmd.blend && valid_s1) begin
			for (int i = 0; i < 4; i++) acc_q[i] <= nxt[i];
			if (cnt_q < CNT_W'(MAX_LAYERS)) cnt_q <= cnt_q + 1'b1;
		end
	end

	// Restoring divider, three colour channels in parallel, one bit a cycle.
	// The numerator is taken from the blend of the closing layer when it has one.
	logic [ACC_W:0] rem_q [3];
	logic [ACC_W+16-1:0] num_q [3];
	logic [QW-1:0] quo_q [3];
	logic [5:0] dcnt_q;
	localparam logic [5:0] DIV_STEPS = 6'(ACC_W + 16);
	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			for (int i = 0; i < 3; i++) begin
				rem_q[i] <= '0;
				num_q[i] <= {(cmd.blend && valid_s1) ? nxt[i] : acc_q[i], 16'd0};
				quo_q[i] <= '0;
			end
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			for (int i = 0; i < 3; i++) begin
				logic [ACC_W+1:0] t;
				t = {rem_q[i], num_q[i][ACC_W+15]};
				num_q[i] <= num_q[i] << 1;
				if (t >= {2'b00, acc_q[3]}) begin
					rem_q[i] <= (ACC_W+1)'(t - {2'b00, acc_q[3]});
					quo_q[i] <= (quo_q[i][QW-1] || quo_q[i] > QW'(ONE_FX))
						? quo_q[i] : {quo_q[i][QW-2:0], 1'b1};
				end else begin
					rem_q[i] <= t[ACC_W:0];
					quo_q[i] <= (quo_q[i][QW-1] || quo_q[i] > QW'(ONE_FX))
						? quo_q[i] : {quo_q[i][QW-2:0], 1'b0};
				end
			end
			dcnt_q <= dcnt_q + 1'b1;
		end
	end
	// Once a quotient exceeds 1.0 it is frozen; the clamp only needs "above".
	assign stat.div_done = (dcnt_q == DIV_STEPS - 1'b1) && cmd.div_step;
	// Judged on the state as it stands once the layer in stage 1 has been folded in.
	assign stat.fast_result = (fault_q != ST_OK)
		|| (valid_s1 ? (nxt[3] == '0) : ((cnt_q == '0) || (acc_q[3] == '0)));

	function automatic logic [CH_W-1:0] clamp_q(input logic [QW-1:0] q);
		return (q > QW'(ONE_FX)) ? ONE_FX : q[CH_W-1:0];
	endfunction

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			red_out <= '0;
			green_out <= '0;
			blue_out <= '0;
			alpha_out <= '0;
			if (fault_q != ST_OK) begin
				status <= fault_q;
				position <= POS_W'(fidx_q);
			end else if (cnt_q == '0) begin
				status <= ST_EMPTY;
				position <= '0;
			end else begin
				status <= ST_OK;
				position <= POS_W'(cnt_q);
				alpha_out <= (acc_q[3] > ACC_W'(ONE_FX)) ? ONE_FX : acc_q[3][CH_W-1:0];
				if (acc_q[3] != '0) begin
					red_out <= clamp_q(quo_q[0]);
					green_out <= clamp_q(quo_q[1]);
					blue_out <= clamp_q(quo_q[2]);
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> rtl/aosc_ctrl.sv
// Controller: sequences layer blend, division and result hand-over.
// Depends on aosc_pkg.
`default_nettype none
module aosc_ctrl import aosc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_last,
	output logic in_ready,
	output logic out_valid,
	input wire logic out_ready,
	output dp_cmd_t cmd,
	input wire dp_stat_t stat
);
	ctrl_state_t state_q, state_d;
	logic ov_q, ov_d;
	logic in_last_q;
	logic take;
	assign take = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (take) state_d = S_BLEND;
			S_BLEND: state_d = in_last_q ? (stat.fast_result ? S_OUT : S_DIV) : S_IDLE;
			S_DIV: if (stat.div_done) state_d = S_OUT;
			S_OUT: if (!ov_q || out_ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
			in_last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q <= ov_d;
			if (take) in_last_q <= in_last;
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		ov_d = ov_q && !out_ready;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_BLEND: begin
				cmd.blend = 1'b1;
				cmd.div_start = in_last_q;
			end
			S_DIV: cmd.div_step = 1'b1;
			S_OUT: if (!ov_q || out_ready) begin
				cmd.out_load = 1'b1;
				cmd.clear = 1'b1;
				ov_d = 1'b1;
			end
			default: ;
		endcase
	end
	assign out_valid = ov_q;
endmodule
`default_nettype wire

>>> verif/tb_alpha_over_stack_compositor_top.sv
// Self-checking testbench for the source-over layer stack compositor.
// Depends on aosc_pkg, aosc_stream_if and alpha_over_stack_compositor_top.
// Stimulus is a directed table followed by random stacks and one deep stack, checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb_alpha_over_stack_compositor_top;
	import aosc_pkg::*;

	// One layer transaction as carried on the input channel.
	typedef struct packed {
		logic has_layer;
		logic [CH_W-1:0] red_in;
		logic [CH_W-1:0] green_in;
		logic [CH_W-1:0] blue_in;
		logic [CH_W-1:0] alpha_in;
		logic last_layer;
	} layer_t;

	// One composited pixel as carried on the output channel.
	typedef struct packed {
		logic [1:0] status;
		logic [POS_W-1:0] position;
		logic [CH_W-1:0] red_out;
		logic [CH_W-1:0] green_out;
		logic [CH_W-1:0] blue_out;
		logic [CH_W-1:0] alpha_out;
	} pixel_t;

	// A row of the directed table: the layer, and where the result can be read
	// off at a glance, the pixel that it must produce.
	typedef struct {
		layer_t layer;
		bit typed;
		pixel_t pixel;
	} stim_row_t;

	localparam longint unsigned ONE = 65536;
	localparam int unsigned STACK_LIMIT = DEF_MAX_LAYERS;
	localparam int unsigned LAYER_W = $bits(layer_t);

	logic clk;
	logic arst_n;

	aosc_stream_if #(.payload_t(layer_t)) in_ch ();
	aosc_stream_if #(.payload_t(pixel_t)) out_ch ();

	alpha_over_stack_compositor_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Predictor state: premultiplied accumulators, layer count and fault record.
	longint unsigned prem_red, prem_green, prem_blue, prem_alpha;
	int unsigned layers_seen;
	logic [1:0] fault_status;
	int unsigned fault_layer;

	pixel_t pending_pixels[$];
	int unsigned mismatches;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_request;

	// The clock runs from time zero with a 20 ns period.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// The safety net: a correct run ends long before this.
	initial begin
		#20_000_000;
		$display("** alpha_over_stack_compositor_top: FAILED **");
		$finish;
	end

	function automatic void clear_stack();
		prem_red = 0;
		prem_green = 0;
		prem_blue = 0;
		prem_alpha = 0;
		layers_seen = 0;
		fault_status = ST_OK;
		fault_layer = 0;
	endfunction

	function automatic longint unsigned straighten(longint unsigned prem, longint unsigned alpha);
		longint unsigned quot;
		if (alpha == 0) return 0;
		quot = (prem << 16) / alpha;
		return (quot > ONE) ? ONE : quot;
	endfunction

	// Folds one layer into the running stack; returns 1 with the pixel when the
	// transaction closes the stack.
	function automatic bit composite_layer(input layer_t lyr, output pixel_t pix);
		longint unsigned r, g, b, a, inv;
		r = lyr.red_in;
		g = lyr.green_in;
		b = lyr.blue_in;
		a = lyr.alpha_in;
		pix = '0;
		if (lyr.has_layer && fault_status == ST_OK) begin
			if (r > ONE || g > ONE || b > ONE || a > ONE) begin
				fault_status = ST_INVALID;
				fault_layer = layers_seen;
			end else if (a == 0 && (r != 0 || g != 0 || b != 0)) begin
				fault_status = ST_HIDDEN;
				fault_layer = layers_seen;
			end else begin
				inv = ONE - a;
				prem_red = ((r * a) >> 16) + ((prem_red * inv) >> 16);
				prem_green = ((g * a) >> 16) + ((prem_green * inv) >> 16);
				prem_blue = ((b * a) >> 16) + ((prem_blue * inv) >> 16);
				prem_alpha = a + ((prem_alpha * inv) >> 16);
				if (layers_seen < STACK_LIMIT) layers_seen++;
			end
		end
		if (!lyr.last_layer) return 0;
		if (fault_status != ST_OK) begin
			pix.status = fault_status;
			pix.position = fault_layer[POS_W-1:0];
		end else if (layers_seen == 0) begin
			pix.status = ST_EMPTY;
		end else begin
			pix.status = ST_OK;
			pix.position = layers_seen[POS_W-1:0];
			pix.red_out = CH_W'(straighten(prem_red, prem_alpha));
			pix.green_out = CH_W'(straighten(prem_green, prem_alpha));
			pix.blue_out = CH_W'(straighten(prem_blue, prem_alpha));
			pix.alpha_out = CH_W'((prem_alpha > ONE) ? ONE : prem_alpha);
		end
		clear_stack();
		return 1;
	endfunction

	// Offers one layer, idling first as the current phase asks, and returns once
	// the transaction has been accepted. Valid is left high so that a following
	// layer without a gap is offered back to back.
	task automatic offer_layer(input layer_t lyr, input bit typed, input pixel_t typed_pix);
		pixel_t pix;
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.payload <= LAYER_W'({$urandom, $urandom, $urandom});
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.payload <= lyr;
		do @(posedge clk); while (!in_ch.ready);
		if (composite_layer(lyr, pix)) pending_pixels.push_back(typed ? typed_pix : pix);
	endtask

	// Drops valid and waits until every predicted pixel has been taken, then
	// lets the bench idle before it returns.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	function automatic logic [CH_W-1:0] rand_channel();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 8) return '0;
		if (pick < 16) return CH_W'(ONE);
		if (pick < 20) return CH_W'($urandom); // full 17-bit range, about half invalid
		return CH_W'($urandom_range(65536));
	endfunction

	// Random layer; a small share breaks the rules to reach the fault paths.
	function automatic layer_t rand_layer(input bit last);
		layer_t lyr;
		int unsigned pick;
		lyr.has_layer = 1'b1;
		lyr.last_layer = last;
		lyr.red_in = CH_W'($urandom_range(65536));
		lyr.green_in = CH_W'($urandom_range(65536));
		lyr.blue_in = CH_W'($urandom_range(65536));
		lyr.alpha_in = CH_W'($urandom_range(65536));
		pick = $urandom_range(99);
		if (pick < 4) begin
			lyr.red_in = rand_channel();
			lyr.green_in = rand_channel();
			lyr.blue_in = rand_channel();
			lyr.alpha_in = rand_channel();
		end else if (pick < 7) begin
			lyr.alpha_in = '0;
		end else if (pick < 12) begin
			lyr.alpha_in = CH_W'(ONE);
		end else if (pick < 16) begin
			lyr.has_layer = 1'b0;
			lyr.red_in = CH_W'($urandom);
			lyr.alpha_in = CH_W'($urandom);
		end
		return lyr;
	endfunction

	// Sends one random stack of the given depth; the closing transaction is
	// sometimes a bare end marker.
	task automatic send_stack(input int unsigned depth);
		layer_t lyr;
		for (int unsigned i = 0; i < depth; i++) begin
			lyr = rand_layer(i == depth - 1);
			if (i == depth - 1 && $urandom_range(9) == 0) begin
				lyr.has_layer = 1'b0;
				lyr.red_in = CH_W'($urandom);
				lyr.green_in = CH_W'($urandom);
				lyr.blue_in = CH_W'($urandom);
				lyr.alpha_in = CH_W'($urandom);
			end
			offer_layer(lyr, 1'b0, '0);
		end
	endtask

	function automatic layer_t mk(input bit has, input int unsigned r, input int unsigned g,
			input int unsigned b, input int unsigned a, input bit last);
		return '{has, r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0], a[CH_W-1:0], last};
	endfunction

	function automatic pixel_t px(input logic [1:0] st, input int unsigned pos,
			input int unsigned r, input int unsigned g, input int unsigned b, input int unsigned a);
		return '{st, pos[POS_W-1:0], r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0], a[CH_W-1:0]};
	endfunction

	// Output side: every accepted result transaction is compared against the
	// oldest predicted pixel. Ready is redrawn each cycle, or held low while a
	// long hold-off is counted down so that the block backs up onto its input.
	always @(posedge clk) begin
		pixel_t want, got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = out_ch.payload;
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result status=%0d pos=%0d", $realtime,
						got.status, got.position);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch exp st=%0d pos=%0d rgba=%0d %0d %0d %0d, got st=%0d pos=%0d rgba=%0d %0d %0d %0d",
							$realtime, want.status, want.position, want.red_out,
							want.green_out, want.blue_out, want.alpha_out, got.status,
							got.position, got.red_out, got.green_out, got.blue_out,
							got.alpha_out);
				end
			end
		end
		if (hold_request != 0) begin
			hold_request <= hold_request - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		stim_row_t table_rows[$];
		int unsigned sent;
		int unsigned depth;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.payload = '0;
		out_ch.ready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 0;
		clear_stack();

		// Directed cases: empty stack, extremes, both fault kinds and their
		// precedence, layers ignored after a fault, bare markers mid-stack,
		// zero composited alpha and a plain half-transparent blend.
		table_rows.push_back('{mk(0, 0, 0, 0, 0, 1), 1, px(ST_EMPTY, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(0, 131071, 131071, 131071, 131071, 1), 1,
			px(ST_EMPTY, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 0, 0, 1), 1, px(ST_OK, 1, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 65536, 65536, 65536, 65536, 1), 1,
			px(ST_OK, 1, 65536, 65536, 65536, 65536)});
		table_rows.push_back('{mk(1, 65537, 0, 0, 65536, 1), 1, px(ST_INVALID, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 0, 131071, 1), 1, px(ST_INVALID, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 5, 0, 0, 0, 1), 1, px(ST_HIDDEN, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 70000, 0, 1), 1, px(ST_INVALID, 0, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 100, 200, 300, 40000, 0), 0, '0});
		table_rows.push_back('{mk(1, 131071, 131071, 131071, 131071, 0), 0, '0});
		table_rows.push_back('{mk(1, 65536, 0, 0, 0, 0), 0, '0});
		table_rows.push_back('{mk(0, 0, 0, 0, 0, 1), 1, px(ST_INVALID, 1, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 0, 0, 0, 65536, 0), 0, '0});
		table_rows.push_back('{mk(0, 131071, 0, 99, 1, 0), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 1, 0, 1), 1, px(ST_HIDDEN, 1, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 65536, 32768, 0, 32768, 0), 0, '0});
		table_rows.push_back('{mk(1, 0, 65536, 12345, 32768, 1), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 0, 0, 0), 0, '0});
		table_rows.push_back('{mk(1, 0, 0, 0, 0, 1), 1, px(ST_OK, 2, 0, 0, 0, 0)});
		table_rows.push_back('{mk(1, 65536, 65536, 65536, 1, 1), 0, '0});

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			offer_layer(table_rows[i].layer, table_rows[i].typed, table_rows[i].pixel);
		drain();

		// Random stacks across the idling phases. Each phase ends with the
		// sender paused until every expected result has come back.
		sent = 0;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 71; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 71; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			// In the stall-free phase the receiver holds off for a long stretch
			// while the sender keeps offering, so the block fills and stalls.
			if (phase == 0) hold_request = 400;
			while (sent < 345 * (phase + 1)) begin
				depth = ($urandom_range(19) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 6);
				send_stack(depth);
				sent += depth;
			end
			drain();
		end

		// One deep stack runs the layer count into saturation.
		send_idle_pct = 0;
		recv_stall_pct = 20;
		for (int unsigned i = 0; i < STACK_LIMIT + 10; i++)
			offer_layer(mk(1, $urandom_range(65536), $urandom_range(65536),
				$urandom_range(65536), $urandom_range(1, 65536), i == STACK_LIMIT + 9),
				1'b0, '0);
		drain();

		if (mismatches == 0 && pending_pixels.size() == 0) begin
			$display("** alpha_over_stack_compositor_top: PASSED **");
		end else begin
			$display("** alpha_over_stack_compositor_top: FAILED **");
		end
		$finish;
	end
endmodule
`default_nettype wire

>>> alpha_over_stack_compositor_top.f
+incdir+rtl
rtl/aosc_pkg.sv
rtl/aosc_stream_if.sv
rtl/aosc_datapath.sv
rtl/aosc_ctrl.sv
rtl/alpha_over_stack_compositor_top.sv
verif/tb_alpha_over_stack_compositor_top.sv
